/* sv/unsigned_to_padded_decimal_ascii_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the unsigned-to-decimal text converter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_PADDED_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_PADDED_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define U2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u2d check failed");

// Next-cycle implication, disabled while in reset.
`define U2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u2d check failed");

`endif

/* sv/u2d_pkg.sv */
// ----------------------------------------------------------------------------
// u2d_pkg
// Widths, character codes and types for the decimal text converter.
// ----------------------------------------------------------------------------
package u2d_pkg;

    localparam int VALUE_W         = 32;
    localparam int PAD_W           = 5;
    localparam int CHAR_W          = 6;
    localparam int BCD_W           = 4;
    localparam int STEPS_PER_STAGE = 4;

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 6'h20;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'h39;

    localparam logic [BCD_W-1:0] DABBLE_LIM = 4'd5;
    localparam logic [BCD_W-1:0] DABBLE_ADJ = 4'd3;

    typedef enum logic {
        SER_IDLE,
        SER_BUSY
    } t_ser_state;

endpackage

/* sv/u2d_if.sv */
// ----------------------------------------------------------------------------
// u2d_if
// Valid/ready channels for number beats in and character beats out.
// ----------------------------------------------------------------------------
interface u2d_in_if;
    logic                          valid;
    logic                          ready;
    logic [u2d_pkg::VALUE_W-1:0]   value;
    logic [u2d_pkg::PAD_W-1:0]     pad_width;

    modport source (output valid, value, pad_width, input ready);
    modport sink   (input valid, value, pad_width, output ready);
endinterface

interface u2d_out_if;
    logic                          valid;
    logic                          ready;
    logic [u2d_pkg::CHAR_W-1:0]    char_code;
    logic                          last;

    modport source (output valid, char_code, last, input ready);
    modport sink   (input valid, char_code, last, output ready);
endinterface

/* sv/u2d_dabble_stage.sv */
// ----------------------------------------------------------------------------
// u2d_dabble_stage
// One register stage of the shift-and-add-3 binary to BCD pipeline.
// ----------------------------------------------------------------------------
module u2d_dabble_stage #(
    parameter int DIGITS = 10,
    parameter int VB     = 32,
    parameter int STEPS  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2d_pkg::BCD_W*DIGITS+VB-1:0] i_word,
    input  logic [u2d_pkg::PAD_W-1:0]     i_pad,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2d_pkg::BCD_W*DIGITS+VB-1:0] o_word,
    output logic [u2d_pkg::PAD_W-1:0]     o_pad
);

    localparam int W = u2d_pkg::BCD_W * DIGITS + VB;

    logic           r_valid;
    logic [W-1:0]   r_word;
    logic [u2d_pkg::PAD_W-1:0] r_pad;
    logic [W-1:0]   n_word;

    always_comb begin
        n_word = i_word;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (n_word[VB + u2d_pkg::BCD_W*d +: u2d_pkg::BCD_W] >= u2d_pkg::DABBLE_LIM) begin
                    n_word[VB + u2d_pkg::BCD_W*d +: u2d_pkg::BCD_W] =
                        n_word[VB + u2d_pkg::BCD_W*d +: u2d_pkg::BCD_W] + u2d_pkg::DABBLE_ADJ;
                end
            end
            n_word = {n_word[W-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
            r_pad  <= i_pad;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;
    assign o_pad   = r_pad;

endmodule

/* sv/u2d_serial.sv */
// ----------------------------------------------------------------------------
// u2d_serial
// Counts significant digits, emits padding then digits, one a cycle if ready.
// ----------------------------------------------------------------------------
module u2d_serial #(
    parameter int DIGITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [u2d_pkg::BCD_W*DIGITS-1:0]   i_bcd,
    input  logic [u2d_pkg::PAD_W-1:0]          i_pad,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [u2d_pkg::CHAR_W-1:0]         o_char,
    output logic                               o_last
);

    localparam int BW    = u2d_pkg::BCD_W * DIGITS;
    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam int SUB_W = ((CNT_W > u2d_pkg::PAD_W) ? CNT_W : u2d_pkg::PAD_W) + 1;

    u2d_pkg::t_ser_state r_state, n_state;
    logic [BW-1:0]              r_bcd, n_bcd;
    logic [u2d_pkg::PAD_W-1:0]  r_pad_left, n_pad_left;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic                       r_out_valid, n_out_valid;
    logic [u2d_pkg::CHAR_W-1:0] r_char, n_char;
    logic                       r_last, n_last;

    logic [CNT_W-1:0]           cnt;
    logic [SUB_W-1:0]           pad_ext;
    logic [SUB_W-1:0]           cnt_ext;
    logic [u2d_pkg::PAD_W-1:0]  pad_left;
    logic [u2d_pkg::BCD_W-1:0]  cur_digit;
    logic                       advance;

    // highest non-zero digit; zero still gives one digit
    always_comb begin
        cnt = CNT_W'(1);
        for (int d = 0; d < DIGITS; d++) begin
            if (i_bcd[u2d_pkg::BCD_W*d +: u2d_pkg::BCD_W] != '0) begin
                cnt = CNT_W'(d + 1);
            end
        end
    end

    assign pad_ext   = SUB_W'(i_pad);
    assign cnt_ext   = SUB_W'(cnt);
    assign pad_left  = (pad_ext > cnt_ext) ? u2d_pkg::PAD_W'(pad_ext - cnt_ext) : '0;
    assign cur_digit = r_bcd[r_idx*u2d_pkg::BCD_W +: u2d_pkg::BCD_W];
    assign advance   = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_pad_left  = r_pad_left;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        o_ready     = 1'b0;
        case (r_state)
            u2d_pkg::SER_IDLE: begin
                o_ready = 1'b1;
                if (i_ready) begin
                    n_out_valid = 1'b0;
                end
                if (i_valid) begin
                    n_bcd      = i_bcd;
                    n_pad_left = pad_left;
                    n_idx      = IDX_W'(cnt - CNT_W'(1));
                    n_state    = u2d_pkg::SER_BUSY;
                end
            end
            u2d_pkg::SER_BUSY: begin
                if (advance) begin
                    n_out_valid = 1'b1;
                    if (r_pad_left != '0) begin
                        n_char     = u2d_pkg::ASCII_SPACE;
                        n_last     = 1'b0;
                        n_pad_left = r_pad_left - 1'b1;
                    end else begin
                        n_char = u2d_pkg::ASCII_ZERO
                                 + {{(u2d_pkg::CHAR_W-u2d_pkg::BCD_W){1'b0}}, cur_digit};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = u2d_pkg::SER_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = u2d_pkg::SER_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= u2d_pkg::SER_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd      <= n_bcd;
        r_pad_left <= n_pad_left;
        r_idx      <= n_idx;
        r_char     <= n_char;
        r_last     <= n_last;
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

/* sv/unsigned_to_padded_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// unsigned_to_padded_decimal_ascii
// Unsigned binary number to right-aligned decimal ASCII text.
// ----------------------------------------------------------------------------
// i_in carries one number per beat: value and pad_width (minimum field width,
// saturated at MAX_WIDTH). o_out carries one character per beat: spaces for
// padding, then digits most significant first; last marks the final one.
// Zero gives a single '0'; a narrow width truncates nothing.
// Conversion runs through ceil(VALUE_BITS/4) shift-and-add-3 register stages,
// each taking a new number every cycle while the next stage is ready, then a
// serialiser with an output register that takes a new number only when idle,
// after the last character of the previous one; that loop sets throughput.
// Reset (synchronous, active low) empties all stages and drops o_out.valid.
// When the receiver stalls, the output beat holds, the serialiser waits and
// the conversion stages fill up before i_in.ready falls; nothing is lost.
// ----------------------------------------------------------------------------
module unsigned_to_padded_decimal_ascii #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_WIDTH  = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u2d_in_if.sink            i_in,
    u2d_out_if.source         o_out
);

    localparam int VB      = (VALUE_BITS < u2d_pkg::VALUE_W) ? VALUE_BITS : u2d_pkg::VALUE_W;
    localparam int DIGITS  = (VB * 30103) / 100000 + 1;
    localparam int W       = u2d_pkg::BCD_W * DIGITS + VB;
    localparam int STP     = u2d_pkg::STEPS_PER_STAGE;
    localparam int NSTG    = (VB + STP - 1) / STP;
    localparam int PAD_MAX = (1 << u2d_pkg::PAD_W) - 1;
    localparam int PAD_LIM = (MAX_WIDTH < PAD_MAX) ? MAX_WIDTH : PAD_MAX;

    logic [W-1:0]              s_word  [NSTG+1];
    logic [u2d_pkg::PAD_W-1:0] s_pad   [NSTG+1];
    logic                      s_valid [NSTG+1];
    logic                      s_ready [NSTG+1];

    assign s_word[0]  = {{(u2d_pkg::BCD_W*DIGITS){1'b0}}, i_in.value[VB-1:0]};
    assign s_pad[0]   = (i_in.pad_width > u2d_pkg::PAD_W'(PAD_LIM))
                        ? u2d_pkg::PAD_W'(PAD_LIM) : i_in.pad_width;
    assign s_valid[0] = i_in.valid;
    assign i_in.ready = s_ready[0];

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        localparam int STEPS = (g == NSTG - 1) ? (VB - STP * (NSTG - 1)) : STP;

        u2d_dabble_stage #(
            .DIGITS (DIGITS),
            .VB     (VB),
            .STEPS  (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_word  (s_word[g]),
            .i_pad   (s_pad[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_word  (s_word[g+1]),
            .o_pad   (s_pad[g+1])
        );
    end

    u2d_serial #(
        .DIGITS (DIGITS)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[NSTG]),
        .o_ready (s_ready[NSTG]),
        .i_bcd   (s_word[NSTG][W-1:VB]),
        .i_pad   (s_pad[NSTG]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_char  (o_out.char_code),
        .o_last  (o_out.last)
    );

endmodule

/* sv/u2d_checker.sv */
// ----------------------------------------------------------------------------
// u2d_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
`include "unsigned_to_padded_decimal_ascii_macros.svh"

module u2d_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [u2d_pkg::CHAR_W-1:0]   i_out_char,
    input logic                         i_out_last
);

    `U2D_ASSERT_NEXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid)

    `U2D_ASSERT_NEXT(a_beat_hold, i_out_valid && !i_out_ready, $stable(i_out_char) && $stable(i_out_last))

    `U2D_ASSERT_NOW(a_char_set, i_out_valid, (i_out_char == u2d_pkg::ASCII_SPACE) || ((i_out_char >= u2d_pkg::ASCII_ZERO) && (i_out_char <= u2d_pkg::ASCII_NINE)))

    `U2D_ASSERT_NOW(a_space_not_last, i_out_valid && i_out_last, i_out_char != u2d_pkg::ASCII_SPACE)

    // within one number, a digit is never followed by padding
    `U2D_ASSERT_NEXT(a_no_pad_after_digit, i_out_valid && i_out_ready && !i_out_last && (i_out_char != u2d_pkg::ASCII_SPACE), !i_out_valid || (i_out_char != u2d_pkg::ASCII_SPACE))

endmodule

bind unsigned_to_padded_decimal_ascii u2d_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_code),
    .i_out_last  (o_out.last)
);

/* tb/sv/unsigned_to_padded_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_padded_decimal_ascii_tb
// Sends numbers with field widths through the converter and checks every
// character beat against text predicted in the bench: leading spaces, digits
// most significant first, last on the final one. Directed corner cases come
// first, then random numbers with gaps and stalls on both sides, one side or none.
// ----------------------------------------------------------------------------
module unsigned_to_padded_decimal_ascii_tb;

    localparam int MAX_WIDTH   = 31;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic [u2d_pkg::CHAR_W-1:0] char_code;
        logic                       last;
    } t_text_char;

    logic i_clk;
    logic i_rst_n;

    u2d_in_if  num_ch ();
    u2d_out_if text_ch ();

    t_text_char expected_chars[$];
    int         bad_beats;
    bit         sender_pauses;
    bit         receiver_stalls;

    unsigned_to_padded_decimal_ascii #(
        .VALUE_BITS (u2d_pkg::VALUE_W),
        .MAX_WIDTH  (MAX_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (num_ch),
        .o_out   (text_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Expected text of one number, appended to the store.
    function automatic void predict_text(input logic [u2d_pkg::VALUE_W-1:0] value,
                                         input logic [u2d_pkg::PAD_W-1:0] pad);
        logic [3:0]                  digit_buf [0:9];
        logic [u2d_pkg::VALUE_W-1:0] rest;
        int                          n_digits;
        int                          width;
        int                          n_spaces;
        t_text_char                  c;
        rest     = value;
        n_digits = 0;
        do begin
            digit_buf[n_digits] = 4'(rest % 10);
            rest = rest / 10;
            n_digits++;
        end while (rest != 0);
        width    = (int'(pad) > MAX_WIDTH) ? MAX_WIDTH : int'(pad);
        n_spaces = (width > n_digits) ? width - n_digits : 0;
        for (int i = 0; i < n_spaces; i++) begin
            c.char_code = u2d_pkg::ASCII_SPACE;
            c.last      = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            c.char_code = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(digit_buf[i]);
            c.last      = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic logic [u2d_pkg::VALUE_W-1:0] rand_value();
        logic [u2d_pkg::VALUE_W-1:0] v;
        int                          pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2: v = $urandom_range(0, 999);
            default: begin
                v = 1;
                repeat ($urandom_range(0, 9)) v = v * 10;
                v = v + $urandom_range(0, 2) - 1;
            end
        endcase
        return v;
    endfunction

    // One number beat; called at a rising edge, returns at its acceptance.
    task automatic send_number(input logic [u2d_pkg::VALUE_W-1:0] value,
                               input logic [u2d_pkg::PAD_W-1:0] pad);
        int gap;
        gap = sender_pauses ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            num_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        num_ch.valid     <= 1'b1;
        num_ch.value     <= value;
        num_ch.pad_width <= pad;
        do @(posedge i_clk); while (!(num_ch.valid && num_ch.ready));
        predict_text(value, pad);
    endtask

    // Receiver: random stall before each character beat.
    initial begin
        int stall;
        text_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = receiver_stalls ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                text_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            text_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(text_ch.valid === 1'b1 && text_ch.ready));
        end
    end

    always @(posedge i_clk) begin
        t_text_char exp_c;
        if (i_rst_n && text_ch.valid === 1'b1 && text_ch.ready) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected beat char_code=%h last=%b",
                         $time, text_ch.char_code, text_ch.last);
                bad_beats++;
            end else begin
                exp_c = expected_chars.pop_front();
                if (text_ch.char_code !== exp_c.char_code) begin
                    $display("%0t: char_code expected %h actual %h",
                             $time, exp_c.char_code, text_ch.char_code);
                    bad_beats++;
                end
                if (text_ch.last !== exp_c.last) begin
                    $display("%0t: last expected %b actual %b",
                             $time, exp_c.last, text_ch.last);
                    bad_beats++;
                end
            end
        end
    end

    task automatic test_zero();
        send_number(32'd0, 5'd0);
        send_number(32'd0, 5'd1);
        send_number(32'd0, 5'd31);
        send_number(32'd1, 5'd0);
    endtask

    task automatic test_padding();
        send_number(32'd9, 5'd2);
        send_number(32'd10, 5'd3);
        send_number(32'd99, 5'd2);
        send_number(32'd100, 5'd4);
        send_number(32'd12345, 5'd6);
        send_number(32'd12345, 5'd31);
    endtask

    task automatic test_narrow_width();
        send_number(32'd12345, 5'd2);
        send_number(32'd12345, 5'd5);
        send_number(32'd10, 5'd1);
        send_number(32'd999999999, 5'd9);
    endtask

    // Ten-digit values, up to the largest unsigned 32-bit word.
    task automatic test_wide_values();
        send_number(32'd4294967295, 5'd0);
        send_number(32'd4294967295, 5'd10);
        send_number(32'd4294967295, 5'd31);
        send_number(32'd2147483647, 5'd0);
        send_number(32'd2147483648, 5'd11);
        send_number(32'd1999999999, 5'd0);
        send_number(32'd3999999999, 5'd15);
        send_number(32'd1000000000, 5'd0);
    endtask

    task automatic test_random(input int n_items);
        repeat (n_items) send_number(rand_value(), u2d_pkg::PAD_W'($urandom_range(0, 31)));
    endtask

    initial begin
        bad_beats        = 0;
        sender_pauses    = 1'b1;
        receiver_stalls  = 1'b1;
        i_rst_n          <= 1'b0;
        num_ch.valid     <= 1'b0;
        num_ch.value     <= '0;
        num_ch.pad_width <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero();
        test_padding();
        test_narrow_width();
        test_wide_values();

        test_random(50);
        sender_pauses   = 1'b0;
        receiver_stalls = 1'b0;
        test_random(45);
        receiver_stalls = 1'b1;
        test_random(45);
        sender_pauses   = 1'b1;
        receiver_stalls = 1'b0;
        test_random(45);

        num_ch.valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (bad_beats == 0 && expected_chars.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
